// ----- design/dmps_pkg.sv -----
// shared types and constants for the dual motor pid speed controller
// depends on nothing; used by every module of the block by scoped names
`timescale 1ns / 1ps

package dmps_pkg;

	// fixed field widths
	localparam int GAIN_W = 16;
	localparam int SPEED_W = 16;
	localparam int DUTY_W = 16;
	localparam int ERR_W = SPEED_W + 1;
	localparam int DERR_W = ERR_W + 1;
	localparam int PROP_W = ERR_W + GAIN_W + 1;
	localparam int DER_W = DERR_W + GAIN_W + 1;
	localparam int PD_W = DER_W + 1;

	// configuration port
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// register indexes
	typedef enum logic [2:0] {
		REG_LEFT_PROP = 3'd0,
		REG_LEFT_INTEG = 3'd1,
		REG_LEFT_DERIV = 3'd2,
		REG_RIGHT_PROP = 3'd3,
		REG_RIGHT_INTEG = 3'd4,
		REG_RIGHT_DERIV = 3'd5,
		REG_DUTY_CEILING = 3'd6,
		REG_DUTY_FLOOR = 3'd7
	} reg_index_t;

	// reset values
	localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;
	localparam logic [DUTY_W-1:0] DUTY_CEILING_RST = 16'hFFFF;
	localparam logic [DUTY_W-1:0] DUTY_FLOOR_RST = 16'd0;

	// gains of one lane
	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] deriv;
	} lane_gain_t;

	// whole register file
	typedef struct packed {
		lane_gain_t left;
		lane_gain_t right;
		logic [DUTY_W-1:0] duty_ceiling;
		logic [DUTY_W-1:0] duty_floor;
	} cfg_t;

	// pipeline load enables shared by both lanes
	typedef struct packed {
		logic take;
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

// ----- design/dmps_regs.sv -----
// apb-style register file holding gains and duty limits
// depends on dmps_pkg
`timescale 1ns / 1ps

module dmps_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dmps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dmps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dmps_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	output dmps_pkg::cfg_t cfg
);

	dmps_pkg::cfg_t cfg_q;
	dmps_pkg::reg_index_t idx;
	logic wr_en;
	logic [dmps_pkg::GAIN_W-1:0] rd_val;

	assign pready = 1'b1;
	assign idx = dmps_pkg::reg_index_t'(paddr[4:2]);
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left.prop <= dmps_pkg::PROP_GAIN_RST;
			cfg_q.left.integ <= dmps_pkg::INTEG_GAIN_RST;
			cfg_q.left.deriv <= dmps_pkg::DERIV_GAIN_RST;
			cfg_q.right.prop <= dmps_pkg::PROP_GAIN_RST;
			cfg_q.right.integ <= dmps_pkg::INTEG_GAIN_RST;
			cfg_q.right.deriv <= dmps_pkg::DERIV_GAIN_RST;
			cfg_q.duty_ceiling <= dmps_pkg::DUTY_CEILING_RST;
			cfg_q.duty_floor <= dmps_pkg::DUTY_FLOOR_RST;
		end else if (wr_en) begin
			case (idx)
				dmps_pkg::REG_LEFT_PROP: cfg_q.left.prop <= pwdata[15:0];
				dmps_pkg::REG_LEFT_INTEG: cfg_q.left.integ <= pwdata[15:0];
				dmps_pkg::REG_LEFT_DERIV: cfg_q.left.deriv <= pwdata[15:0];
				dmps_pkg::REG_RIGHT_PROP: cfg_q.right.prop <= pwdata[15:0];
				dmps_pkg::REG_RIGHT_INTEG: cfg_q.right.integ <= pwdata[15:0];
				dmps_pkg::REG_RIGHT_DERIV: cfg_q.right.deriv <= pwdata[15:0];
				dmps_pkg::REG_DUTY_CEILING: cfg_q.duty_ceiling <= pwdata[15:0];
				dmps_pkg::REG_DUTY_FLOOR: cfg_q.duty_floor <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			dmps_pkg::REG_LEFT_PROP: rd_val = cfg_q.left.prop;
			dmps_pkg::REG_LEFT_INTEG: rd_val = cfg_q.left.integ;
			dmps_pkg::REG_LEFT_DERIV: rd_val = cfg_q.left.deriv;
			dmps_pkg::REG_RIGHT_PROP: rd_val = cfg_q.right.prop;
			dmps_pkg::REG_RIGHT_INTEG: rd_val = cfg_q.right.integ;
			dmps_pkg::REG_RIGHT_DERIV: rd_val = cfg_q.right.deriv;
			dmps_pkg::REG_DUTY_CEILING: rd_val = cfg_q.duty_ceiling;
			dmps_pkg::REG_DUTY_FLOOR: rd_val = cfg_q.duty_floor;
			default: rd_val = '0;
		endcase
	end

	assign prdata = {{(dmps_pkg::APB_DATA_W-dmps_pkg::GAIN_W){1'b0}}, rd_val};

endmodule

// ----- design/dmps_lane.sv -----
// one pid lane: error, saturating integral, derivative and the weighted total
// depends on dmps_pkg; load enables come from the top level control
`timescale 1ns / 1ps

module dmps_lane #(
	parameter int SUM_WIDTH = 32,
	parameter int TOT_W = SUM_WIDTH + 19
) (
	input  logic clk,
	input  logic arst_n,
	input  dmps_pkg::adv_t adv,
	input  dmps_pkg::lane_gain_t gain,
	input  logic signed [dmps_pkg::SPEED_W-1:0] target,
	input  logic signed [dmps_pkg::SPEED_W-1:0] measured,
	output logic signed [TOT_W-1:0] total,
	output logic stop
);

	localparam int LO_W = SUM_WIDTH / 2;
	localparam int HI_W = SUM_WIDTH - LO_W;
	localparam int LO_P_W = LO_W + dmps_pkg::GAIN_W + 2;
	localparam int HI_P_W = HI_W + dmps_pkg::GAIN_W + 1;
	localparam int KI_W = SUM_WIDTH + dmps_pkg::GAIN_W + 2;
	localparam int ERR_W = dmps_pkg::ERR_W;
	localparam int DERR_W = dmps_pkg::DERR_W;

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	// channel state
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [ERR_W-1:0] prior_q;

	// stage 1 logic
	logic signed [ERR_W-1:0] err;
	logic signed [DERR_W-1:0] derr;
	logic signed [SUM_WIDTH:0] sum_wide;
	logic signed [SUM_WIDTH-1:0] sum_next;
	logic is_stop;

	// pipeline registers
	logic signed [ERR_W-1:0] err_s1;
	logic signed [DERR_W-1:0] derr_s1;
	logic signed [SUM_WIDTH-1:0] sum_s1;
	logic stop_s1;
	logic signed [dmps_pkg::PROP_W-1:0] prop_s2;
	logic signed [dmps_pkg::DER_W-1:0] der_s2;
	logic signed [LO_P_W-1:0] lo_s2;
	logic signed [HI_P_W-1:0] hi_s2;
	logic stop_s2;
	logic signed [dmps_pkg::PD_W-1:0] pd_s3;
	logic signed [KI_W-1:0] ki_s3;
	logic stop_s3;
	logic signed [TOT_W-1:0] total_s4;
	logic stop_s4;

	// signed views of the unsigned gains
	logic signed [dmps_pkg::GAIN_W:0] kp_s, ki_s, kd_s;
	assign kp_s = signed'({1'b0, gain.prop});
	assign ki_s = signed'({1'b0, gain.integ});
	assign kd_s = signed'({1'b0, gain.deriv});

	// error, derivative and saturating integral
	always_comb begin
		err = ERR_W'(target) - ERR_W'(measured);
		derr = DERR_W'(err) - DERR_W'(prior_q);
		sum_wide = (SUM_WIDTH+1)'(sum_q) + (SUM_WIDTH+1)'(err);
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end
		is_stop = (target == '0);
	end

	// state update on each accepted beat; a stop clears the channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			prior_q <= '0;
		end else if (adv.take) begin
			if (is_stop) begin
				sum_q <= '0;
				prior_q <= '0;
			end else begin
				sum_q <= sum_next;
				prior_q <= err;
			end
		end
	end

	// stage 1: error terms
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			err_s1 <= err;
			derr_s1 <= derr;
			sum_s1 <= sum_next;
			stop_s1 <= is_stop;
		end
	end

	// stage 2: products, integral term split into two partial products
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prop_s2 <= kp_s * err_s1;
			der_s2 <= kd_s * derr_s1;
			lo_s2 <= ki_s * signed'({1'b0, sum_s1[LO_W-1:0]});
			hi_s2 <= ki_s * signed'(sum_s1[SUM_WIDTH-1:LO_W]);
			stop_s2 <= stop_s1;
		end
	end

	// stage 3: proportional plus derivative, integral recombined
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			pd_s3 <= dmps_pkg::PD_W'(prop_s2) + dmps_pkg::PD_W'(der_s2);
			ki_s3 <= (KI_W'(hi_s2) <<< LO_W) + KI_W'(lo_s2);
			stop_s3 <= stop_s2;
		end
	end

	// stage 4: full total
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			total_s4 <= TOT_W'(ki_s3) + TOT_W'(pd_s3);
			stop_s4 <= stop_s3;
		end
	end

	assign total = total_s4;
	assign stop = stop_s4;

endmodule

// ----- design/dmps_merge.sv -----
// output stage: scales and clamps both lane totals into one result beat
// depends on dmps_pkg
`timescale 1ns / 1ps

module dmps_merge #(
	parameter int TOT_W = 51,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic clk,
	input  logic load,
	input  logic [dmps_pkg::DUTY_W-1:0] duty_ceiling,
	input  logic [dmps_pkg::DUTY_W-1:0] duty_floor,
	input  logic signed [TOT_W-1:0] left_total,
	input  logic left_stop,
	input  logic signed [TOT_W-1:0] right_total,
	input  logic right_stop,
	output logic [dmps_pkg::DUTY_W-1:0] left_duty,
	output logic [dmps_pkg::DUTY_W-1:0] right_duty
);

	localparam int DW = dmps_pkg::DUTY_W;

	logic signed [TOT_W-1:0] ceil_x, floor_x;
	logic [DW-1:0] left_d, right_d;
	logic [DW-1:0] left_duty_q, right_duty_q;

	assign ceil_x = signed'({{(TOT_W-DW){1'b0}}, duty_ceiling});
	assign floor_x = signed'({{(TOT_W-DW){1'b0}}, duty_floor});

	// floor shift, ceiling first then floor, stop forces zero
	function automatic logic [DW-1:0] clamp_duty(
		input logic signed [TOT_W-1:0] tot,
		input logic signed [TOT_W-1:0] hi,
		input logic signed [TOT_W-1:0] lo,
		input logic stop_i
	);
		logic signed [TOT_W-1:0] scaled;
		logic signed [TOT_W-1:0] capped;
		logic signed [TOT_W-1:0] held;
		scaled = tot >>> GAIN_FRAC_BITS;
		capped = (scaled > hi) ? hi : scaled;
		held = (capped < lo) ? lo : capped;
		return stop_i ? '0 : held[DW-1:0];
	endfunction

	always_comb begin
		left_d = clamp_duty(left_total, ceil_x, floor_x, left_stop);
		right_d = clamp_duty(right_total, ceil_x, floor_x, right_stop);
	end

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			left_duty_q <= left_d;
			right_duty_q <= right_d;
		end
	end

	assign left_duty = left_duty_q;
	assign right_duty = right_duty_q;

endmodule

// ----- design/dual_motor_pid_speed.sv -----
// top level of the two-lane pid speed controller
// depends on dmps_pkg, dmps_regs, dmps_lane and dmps_merge
`timescale 1ns / 1ps

// Two-channel PID speed controller. Each input beat carries a target and a
// measured count per motor; each result beat carries the clamped PWM duty per
// motor. The block takes one beat per cycle while in_stall is low. Its
// error and integral registers load at the accepting edge, followed by one
// stage for the multiplies, two adds, and the clamp into the output register.
// Both motors run in identical lanes side by side. A stall on the result side
// holds the pipeline and backs up to in_stall only once all stages hold data.
// Gains and duty limits go over the APB port (register i at byte address 4*i);
// the user must write them only while no beat is in flight (not enforced).

module dual_motor_pid_speed #(
	parameter int SUM_WIDTH = 32,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [dmps_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [dmps_pkg::APB_DATA_W-1:0] pwdata,
	output logic [dmps_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	// input channel
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [dmps_pkg::SPEED_W-1:0] left_target,
	input  logic signed [dmps_pkg::SPEED_W-1:0] left_measured,
	input  logic signed [dmps_pkg::SPEED_W-1:0] right_target,
	input  logic signed [dmps_pkg::SPEED_W-1:0] right_measured,
	// output channel
	output logic out_valid,
	input  logic out_stall,
	output logic [dmps_pkg::DUTY_W-1:0] left_duty,
	output logic [dmps_pkg::DUTY_W-1:0] right_duty
);

	localparam int TOT_W = SUM_WIDTH + 19;

	dmps_pkg::cfg_t cfg;
	dmps_pkg::adv_t adv;

	logic v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic rdy_out, rdy4, rdy3, rdy2, rdy1;
	logic signed [TOT_W-1:0] left_total, right_total;
	logic left_stop, right_stop;

	// stage ready chain: a stage loads when empty or when it moves on
	always_comb begin
		rdy_out = !out_valid_q || !out_stall;
		rdy4 = !v4_s4 || rdy_out;
		rdy3 = !v3_s3 || rdy4;
		rdy2 = !v2_s2 || rdy3;
		rdy1 = !v1_s1 || rdy2;
		adv.take = in_valid && rdy1;
		adv.s1 = rdy1;
		adv.s2 = rdy2;
		adv.s3 = rdy3;
		adv.s4 = rdy4;
	end

	assign in_stall = !rdy1;

	// valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
			if (rdy_out) out_valid_q <= v4_s4;
		end
	end

	assign out_valid = out_valid_q;

	// register file
	dmps_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	// left lane
	dmps_lane #(
		.SUM_WIDTH(SUM_WIDTH),
		.TOT_W(TOT_W)
	) u_lane_left (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.gain(cfg.left),
		.target(left_target),
		.measured(left_measured),
		.total(left_total),
		.stop(left_stop)
	);

	// right lane
	dmps_lane #(
		.SUM_WIDTH(SUM_WIDTH),
		.TOT_W(TOT_W)
	) u_lane_right (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.gain(cfg.right),
		.target(right_target),
		.measured(right_measured),
		.total(right_total),
		.stop(right_stop)
	);

	// clamp and result register
	dmps_merge #(
		.TOT_W(TOT_W),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_merge (
		.clk(clk),
		.load(rdy_out),
		.duty_ceiling(cfg.duty_ceiling),
		.duty_floor(cfg.duty_floor),
		.left_total(left_total),
		.left_stop(left_stop),
		.right_total(right_total),
		.right_stop(right_stop),
		.left_duty(left_duty),
		.right_duty(right_duty)
	);

endmodule
